// ===== design/eiph_pkg.sv =====
// Package for the Ethernet/IPv4/L4 header parser: status codes, the job
// record that the front passes to the back, and fixed header constants.
package eiph_pkg;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ETH_SHORT = 4'd1,
    ST_VLAN_SHORT= 4'd2,
    ST_NOT_IP    = 4'd3,
    ST_IP_BAD    = 4'd4,
    ST_IHL_BAD   = 4'd5,
    ST_PROTO     = 4'd6,
    ST_L4_SHORT  = 4'd7,
    ST_NO_PAYLD  = 4'd8
  } status_t;

  localparam logic [15:0] TYPE_VLAN    = 16'h8100;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [16:0] ETH_LEN      = 17'd14;
  localparam logic [16:0] VLAN_ETH_LEN = 17'd18;
  localparam logic [16:0] IP_MIN       = 17'd20;
  localparam logic [16:0] TCP_MIN      = 17'd20;
  localparam logic [16:0] UDP_LEN      = 17'd8;
  localparam logic [3:0]  NIBBLE       = 4'hF;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;

  // Per-frame record captured by the front end at the last byte.
  typedef struct packed {
    logic [15:0] frame_len;
    logic        vlan_seen;
    logic [15:0] frame_type;
    logic [5:0]  header_bytes;
    logic [5:0]  offset_bytes;
    logic [15:0] udp_total_length;
    logic [63:0] reg0;
    logic [63:0] reg1;
    logic [63:0] reg2;
    logic [63:0] reg3;
  } job_t;

  // Result record handed to the output queue.
  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] error_total;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  flag_bits;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [15:0] window_size;
    logic [15:0] payload_length;
  } result_t;

endpackage

// ===== design/eth_ipv4_l4_header_parser.sv =====
// Ethernet/IPv4/TCP-UDP header parser. Takes one frame byte per clock
// whenever full is low, a rate set by the byte-capture front end. The front
// end registers a job, the back end its result, and the queue stores it.
// Full rises only when the 4-entry queue is nearly full. Depends on eiph_pkg.
module eth_ipv4_l4_header_parser #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status,
  output logic [31:0] error_total,
  output logic [7:0]  protocol,
  output logic [31:0] source_address,
  output logic [31:0] dest_address,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [7:0]  flag_bits,
  output logic [31:0] sequence_number,
  output logic [31:0] ack_number,
  output logic [15:0] window_size,
  output logic [15:0] payload_length
);
  import eiph_pkg::*;

  logic    take, job_valid, res_valid, afull;
  job_t    job;
  result_t res, head;

  assign full = afull;
  assign take = push && !full;

  eiph_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk, .rst, .take, .data_byte, .last_byte, .job_valid, .job);

  eiph_back u_back (.clk, .rst, .job_valid, .job, .res_valid, .res);

  eiph_queue #(.DEPTH(4)) u_queue (
    .clk, .rst, .wr(res_valid), .wdata(res), .rd(pop && !empty),
    .empty, .almost_full(afull), .rdata(head));

  assign status = head.status;
  assign error_total = head.error_total;
  assign protocol = head.protocol;
  assign source_address = head.source_address;
  assign dest_address = head.dest_address;
  assign source_port = head.source_port;
  assign dest_port = head.dest_port;
  assign flag_bits = head.flag_bits;
  assign sequence_number = head.sequence_number;
  assign ack_number = head.ack_number;
  assign window_size = head.window_size;
  assign payload_length = head.payload_length;
endmodule

// ===== design/eiph_front.sv =====
// Front end: walks the frame byte by byte and captures header fields.
// Depends on eiph_pkg. Emits one job record per frame at the last byte.
module eiph_front #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output logic           job_valid,
  output eiph_pkg::job_t job
);
  import eiph_pkg::*;

  localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);

  logic [15:0] byte_position;
  logic        vlan_seen;
  logic [15:0] frame_type;
  logic [5:0]  header_bytes;
  logic [5:0]  offset_bytes;
  logic [15:0] udp_total_length;
  logic [63:0] r0, r1, r2, r3;

  logic [15:0] pos_n;
  logic        vlan_n;
  logic [15:0] type_n;
  logic [5:0]  hb_n;
  logic [5:0]  ob_n;
  logic [15:0] udp_n;
  logic [63:0] r0_n, r1_n, r2_n, r3_n;
  logic [15:0] q, t;
  logic [15:0] base;
  logic        is_type;
  logic [2:0]  r1_sel, r3_sel;

  // Byte capture; q is offset into the IP header, t into the L4 header
  always_comb begin
    pos_n = byte_position; vlan_n = vlan_seen; type_n = frame_type;
    hb_n = header_bytes; ob_n = offset_bytes; udp_n = udp_total_length;
    r0_n = r0; r1_n = r1; r2_n = r2; r3_n = r3;
    base = vlan_seen ? 16'd18 : 16'd14;
    q = byte_position - base;
    t = q - {10'd0, hb_n};
    // byte lane within the address and sequence/ack words, counted from the top
    r1_sel = 3'd3 - q[2:0];
    r3_sel = 3'd3 - t[2:0];
    is_type = (byte_position == 16'd12) || (byte_position == 16'd13) ||
              (vlan_seen && (byte_position == 16'd16 || byte_position == 16'd17));
    if (byte_position < MAX_POS) begin
      pos_n = byte_position + 16'd1;
      if (is_type) begin
        type_n = {frame_type[7:0], data_byte};
        if (byte_position == 16'd13 && type_n == TYPE_VLAN) vlan_n = 1'b1;
      end else if (byte_position >= base) begin
        if (q == 16'd0) begin
          r0_n[7:0] = data_byte;
          hb_n = {data_byte[3:0], 2'b00};
        end else if (q == 16'd9) begin
          r0_n[15:8] = data_byte;
        end else if (q >= 16'd12 && q <= 16'd19) begin
          r1_n[{r1_sel, 3'b000} +: 8] = data_byte;
        end
        t = q - {10'd0, hb_n};
        r3_sel = 3'd3 - t[2:0];
        if (hb_n >= 6'd20 && q >= {10'd0, hb_n}) begin
          if (t <= 16'd3) r2_n[8*(7 - t[1:0]) +: 8] = data_byte;
          else if (t <= 16'd11) begin
            r3_n[{r3_sel, 3'b000} +: 8] = data_byte;
            if (t <= 16'd5) udp_n = {udp_total_length[7:0], data_byte};
          end else if (t == 16'd12) ob_n = {data_byte[7:4], 2'b00};
          else if (t == 16'd13) r2_n[7:0] = data_byte;
          else if (t == 16'd14) r2_n[31:24] = data_byte;
          else if (t == 16'd15) r2_n[23:16] = data_byte;
        end
      end
    end
  end

  // Frame state; cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0; vlan_seen <= 1'b0; frame_type <= '0;
      header_bytes <= '0; offset_bytes <= '0; udp_total_length <= '0;
      r0 <= '0; r1 <= '0; r2 <= '0; r3 <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= take && last_byte;
      if (take) begin
        if (last_byte) begin
          byte_position <= '0; vlan_seen <= 1'b0; frame_type <= '0;
          header_bytes <= '0; offset_bytes <= '0; udp_total_length <= '0;
          r0 <= '0; r1 <= '0; r2 <= '0; r3 <= '0;
        end else begin
          byte_position <= pos_n; vlan_seen <= vlan_n; frame_type <= type_n;
          header_bytes <= hb_n; offset_bytes <= ob_n; udp_total_length <= udp_n;
          r0 <= r0_n; r1 <= r1_n; r2 <= r2_n; r3 <= r3_n;
        end
      end
    end
  end

  // Job record registered at the last byte
  always_ff @(posedge clk) begin
    if (take && last_byte) begin
      job <= '{frame_len: pos_n, vlan_seen: vlan_n, frame_type: type_n,
               header_bytes: hb_n, offset_bytes: ob_n, udp_total_length: udp_n,
               reg0: r0_n, reg1: r1_n, reg2: r2_n, reg3: r3_n};
    end
  end
endmodule

// ===== design/eiph_back.sv =====
// Back end: judges a captured frame, keeps the error count, builds results.
// Depends on eiph_pkg.
module eiph_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  eiph_pkg::job_t    job,
  output logic              res_valid,
  output eiph_pkg::result_t res
);
  import eiph_pkg::*;

  logic [31:0] error_counter;
  logic [16:0] len, base, ipsize, tsize, hb, ob, payload;
  logic [7:0]  ip0, proto;
  status_t     st;
  logic        counted;
  logic [31:0] err_n;
  result_t     res_n;

  // Status decision
  always_comb begin
    len = {1'b0, job.frame_len};
    base = job.vlan_seen ? VLAN_ETH_LEN : ETH_LEN;
    hb = {11'd0, job.header_bytes};
    ob = {11'd0, job.offset_bytes};
    ipsize = (len >= base) ? len - base : '0;
    tsize = (ipsize >= hb) ? ipsize - hb : '0;
    ip0 = job.reg0[7:0];
    proto = job.reg0[15:8];
    payload = '0;
    counted = 1'b1;
    st = ST_OK;
    if (len < ETH_LEN) st = ST_ETH_SHORT;
    else if (job.vlan_seen && len < VLAN_ETH_LEN) begin
      st = ST_VLAN_SHORT; counted = 1'b0;
    end else if (job.frame_type != TYPE_IPV4) begin
      st = ST_NOT_IP; counted = 1'b0;
    end else if (ipsize < IP_MIN || (ip0[7:4] & NIBBLE) != 4'd4) st = ST_IP_BAD;
    else if (hb < IP_MIN || ipsize < hb) st = ST_IHL_BAD;
    else if (proto == PROTO_TCP) begin
      if (tsize < TCP_MIN) st = ST_L4_SHORT;
      else if (tsize <= ob) st = ST_NO_PAYLD;
      else payload = tsize - ob;
    end else if (proto == PROTO_UDP) begin
      if (tsize < UDP_LEN) st = ST_L4_SHORT;
      else if ({1'b0, job.udp_total_length} >= UDP_LEN)
        payload = {1'b0, job.udp_total_length} - UDP_LEN;
    end else st = ST_PROTO;
    err_n = error_counter + ((st != ST_OK && counted) ? 32'd1 : 32'd0);
  end

  // Result fields; everything but status and count is zero on failure
  always_comb begin
    res_n = '0;
    res_n.status = st;
    res_n.error_total = err_n;
    if (st == ST_OK) begin
      res_n.protocol = proto;
      res_n.source_address = job.reg1[63:32];
      res_n.dest_address = job.reg1[31:0];
      res_n.source_port = job.reg2[63:48];
      res_n.dest_port = job.reg2[47:32];
      if (proto == PROTO_TCP) begin
        res_n.flag_bits = job.reg2[7:0];
        res_n.sequence_number = job.reg3[63:32];
        res_n.ack_number = job.reg3[31:0];
        res_n.window_size = job.reg2[31:16];
      end
      res_n.payload_length = payload[15:0];
    end
  end

  // Error counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_counter <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= job_valid;
      if (job_valid) error_counter <= err_n;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) res <= res_n;
  end
endmodule

// ===== design/eiph_queue.sv =====
// Result queue: small FIFO of finished results toward the output side.
// Depends on eiph_pkg.
module eiph_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  eiph_pkg::result_t wdata,
  input  logic              rd,
  output logic              empty,
  output logic              almost_full,
  output eiph_pkg::result_t rdata
);
  import eiph_pkg::*;

  localparam int AW = $clog2(DEPTH);

  result_t        mem [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    count;

  assign empty = (count == '0);
  // two results may still be in flight behind the front
  assign almost_full = (count >= (AW+1)'(DEPTH - 2));
  assign rdata = mem[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end
endmodule

// ===== design/eiph_checker.sv =====
// Port-level checker for the header parser, bound to the top level.
// Depends on eiph_pkg for status codes and on the top-level ports.
module eiph_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        last_byte,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  status,
  input logic [31:0] error_total,
  input logic [7:0]  protocol
);
  import eiph_pkg::*;

  // no result without an accepted final byte ahead of it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(push && !full && last_byte, 3))
    else $error("result without last byte");

  // status stays in the defined code range
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status <= ST_NO_PAYLD)
    else $error("bad status");

  // failed frames carry zero protocol
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> protocol == 8'd0)
    else $error("field on failure");

  // a held result keeps its error total
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(error_total))
    else $error("result changed while held");
endmodule

bind eth_ipv4_l4_header_parser eiph_checker u_checker (
  .clk, .rst, .push, .full, .last_byte, .empty, .pop, .status,
  .error_total, .protocol);

// ===== test/tb_eth_ipv4_l4_header_parser.sv =====
`timescale 1ns / 100ps
// Testbench for the Ethernet/IPv4/TCP-UDP header parser: sends frames byte by
// byte and checks each per-frame result against a predictor in this file.
// Depends on eiph_pkg and eth_ipv4_l4_header_parser.
module tb_eth_ipv4_l4_header_parser;
  import eiph_pkg::*;

  localparam int MAX_BYTES = 16384;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic [3:0]  status;
  logic [31:0] error_total;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  flag_bits;
  logic [31:0] sequence_number;
  logic [31:0] ack_number;
  logic [15:0] window_size;
  logic [15:0] payload_length;

  eth_ipv4_l4_header_parser #(.MAX_FRAME_BYTES(MAX_BYTES)) i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .last_byte(last_byte), .empty(empty), .pop(pop), .status(status),
    .error_total(error_total), .protocol(protocol),
    .source_address(source_address), .dest_address(dest_address),
    .source_port(source_port), .dest_port(dest_port), .flag_bits(flag_bits),
    .sequence_number(sequence_number), .ack_number(ack_number),
    .window_size(window_size), .payload_length(payload_length)
  );

  // Clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predictor state
  logic [15:0] pos_q;
  logic        vlan_q;
  logic [15:0] etype_q;
  logic [5:0]  ihl_bytes_q;
  logic [5:0]  doff_bytes_q;
  logic [15:0] udp_len_q;
  logic [63:0] cap_q [4];
  logic [31:0] err_count_q;

  result_t expected_results[$];
  int  fail_count = 0;
  int  frames_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  bit  hold_rx = 1'b0;
  int  status_hits [9];

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void clear_frame_state();
    pos_q = '0;
    vlan_q = 1'b0;
    etype_q = '0;
    ihl_bytes_q = '0;
    doff_bytes_q = '0;
    udp_len_q = '0;
    for (int i = 0; i < 4; i++) cap_q[i] = '0;
  endfunction

  function automatic void put_cap(int r, int sh, logic [7:0] b);
    cap_q[r][sh +: 8] = b;
  endfunction

  // Header capture for the byte at position p
  function automatic void capture_byte(int unsigned p, logic [7:0] b);
    int unsigned base, q, t;
    if (p == 12 || p == 13 || (vlan_q && (p == 16 || p == 17))) begin
      etype_q = {etype_q[7:0], b};
      if (p == 13 && etype_q == TYPE_VLAN) vlan_q = 1'b1;
      return;
    end
    base = vlan_q ? 18 : 14;
    if (p < base) return;
    q = p - base;
    if (q == 0) begin
      put_cap(0, 0, b);
      ihl_bytes_q = {b[3:0], 2'b00};
    end else if (q == 9) begin
      put_cap(0, 8, b);
    end else if (q >= 12 && q <= 19) begin
      put_cap(1, (19 - q) * 8, b);
    end
    if (ihl_bytes_q < 20 || q < ihl_bytes_q) return;
    t = q - ihl_bytes_q;
    if (t <= 3) begin
      put_cap(2, 56 - 8 * t, b);
    end else if (t <= 11) begin
      put_cap(3, (11 - t) * 8, b);
      if (t <= 5) udp_len_q = {udp_len_q[7:0], b};
    end else if (t == 12) begin
      doff_bytes_q = {b[7:4], 2'b00};
    end else if (t == 13) begin
      put_cap(2, 0, b);
    end else if (t == 14) begin
      put_cap(2, 24, b);
    end else if (t == 15) begin
      put_cap(2, 16, b);
    end
  endfunction

  // Judge the finished frame and build its result
  function automatic result_t judge_frame();
    result_t r;
    int unsigned len, base, ipsize, tsize, payload;
    logic [7:0] ver_ihl, proto;
    status_t st;
    bit counted;
    len = pos_q;
    ver_ihl = cap_q[0][7:0];
    proto = cap_q[0][15:8];
    base = vlan_q ? 18 : 14;
    ipsize = (len >= base) ? len - base : 0;
    tsize = (ipsize >= ihl_bytes_q) ? ipsize - ihl_bytes_q : 0;
    payload = 0;
    counted = 1'b1;
    st = ST_OK;
    if (len < 14) st = ST_ETH_SHORT;
    else if (vlan_q && len < 18) begin
      st = ST_VLAN_SHORT;
      counted = 1'b0;
    end else if (etype_q != TYPE_IPV4) begin
      st = ST_NOT_IP;
      counted = 1'b0;
    end else if (ipsize < 20 || ver_ihl[7:4] != 4'd4) st = ST_IP_BAD;
    else if (ihl_bytes_q < 20 || ipsize < ihl_bytes_q) st = ST_IHL_BAD;
    else if (proto == PROTO_TCP) begin
      if (tsize < 20) st = ST_L4_SHORT;
      else if (tsize <= doff_bytes_q) st = ST_NO_PAYLD;
      else payload = tsize - doff_bytes_q;
    end else if (proto == PROTO_UDP) begin
      if (tsize < 8) st = ST_L4_SHORT;
      else payload = (udp_len_q >= 8) ? udp_len_q - 8 : 0;
    end else st = ST_PROTO;
    if (st != ST_OK && counted) err_count_q = err_count_q + 32'd1;
    r = '0;
    r.status = st;
    r.error_total = err_count_q;
    if (st == ST_OK) begin
      r.protocol = proto;
      r.source_address = cap_q[1][63:32];
      r.dest_address = cap_q[1][31:0];
      r.source_port = cap_q[2][63:48];
      r.dest_port = cap_q[2][47:32];
      if (proto == PROTO_TCP) begin
        r.flag_bits = cap_q[2][7:0];
        r.sequence_number = cap_q[3][63:32];
        r.ack_number = cap_q[3][31:0];
        r.window_size = cap_q[2][31:16];
      end
      r.payload_length = payload[15:0];
    end
    return r;
  endfunction

  // Predict after each accepted byte
  function automatic void predict_byte(logic [7:0] b, logic lst);
    if (pos_q < MAX_BYTES) begin
      capture_byte(pos_q, b);
      pos_q = pos_q + 16'd1;
    end
    if (lst) begin
      expected_results.push_back(judge_frame());
      clear_frame_state();
    end
  endfunction

  // Send one byte: random gap, then hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b, lst);
    if (lst) frames_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] fr[$]);
    for (int i = 0; i < fr.size(); i++) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // Build a frame; proto chooses TCP/UDP/other, other knobs skew content
  function automatic void build_frame(output logic [7:0] fr[$], input bit vlan,
                                      input logic [7:0] proto, input int ihl,
                                      input int doff, input int payload,
                                      input logic [15:0] udp_len);
    fr = {};
    for (int i = 0; i < 12; i++) fr.push_back(rand_byte());
    if (vlan) begin
      fr.push_back(8'h81); fr.push_back(8'h00);
      fr.push_back(rand_byte()); fr.push_back(rand_byte());
    end
    fr.push_back(8'h08); fr.push_back(8'h00);
    fr.push_back({4'd4, ihl[3:0]});
    for (int i = 1; i < ihl * 4; i++)
      fr.push_back(i == 9 ? proto : rand_byte());
    if (proto == PROTO_UDP) begin
      for (int i = 0; i < 4; i++) fr.push_back(rand_byte());
      fr.push_back(udp_len[15:8]); fr.push_back(udp_len[7:0]);
      fr.push_back(rand_byte()); fr.push_back(rand_byte());
    end else begin
      for (int i = 0; i < 12; i++) fr.push_back(rand_byte());
      fr.push_back({doff[3:0], 4'($urandom_range(0, 15))});
      for (int i = 13; i < 20; i++) fr.push_back(rand_byte());
    end
    for (int i = 0; i < payload; i++) fr.push_back(rand_byte());
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.status <= 8) status_hits[exp_r.status]++;
        if ({status, error_total, protocol, source_address, dest_address,
             source_port, dest_port, flag_bits, sequence_number, ack_number,
             window_size, payload_length} !== exp_r) begin
          fail_count++;
          $display("%0t: mismatch status exp %0d act %0d, errors exp %0d act %0d",
                   $time, exp_r.status, status, exp_r.error_total, error_total);
          $display("%0t:   proto exp %0d act %0d, src %h/%h dst %h/%h",
                   $time, exp_r.protocol, protocol, exp_r.source_address,
                   source_address, exp_r.dest_address, dest_address);
          $display("%0t:   ports exp %h %h act %h %h, flags exp %h act %h",
                   $time, exp_r.source_port, exp_r.dest_port, source_port,
                   dest_port, exp_r.flag_bits, flag_bits);
          $display("%0t:   seq exp %h act %h, ack exp %h act %h",
                   $time, exp_r.sequence_number, sequence_number,
                   exp_r.ack_number, ack_number);
          $display("%0t:   window exp %h act %h, payload exp %0d act %0d",
                   $time, exp_r.window_size, window_size,
                   exp_r.payload_length, payload_length);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin
    int gap;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_rx = 1'b0;
      end else if (pop && !empty) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        pop <= 1'b1;
      end else pop <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("eth_ipv4_l4_header_parser test failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [7:0] fr[$];
    // short Ethernet, single byte frame, vlan short, not IP, double VLAN
    fr = {8'hFF}; send_frame(fr);
    fr = {}; repeat (13) fr.push_back(8'h00); send_frame(fr);
    fr = {}; repeat (12) fr.push_back(8'hAA);
    fr.push_back(8'h81); fr.push_back(8'h00); fr.push_back(8'h01); send_frame(fr);
    fr = {}; repeat (12) fr.push_back(8'h55);
    fr.push_back(8'h86); fr.push_back(8'hDD); repeat (40) fr.push_back(8'hFF);
    send_frame(fr);
    fr = {}; repeat (12) fr.push_back(8'h00);
    repeat (2) begin fr.push_back(8'h81); fr.push_back(8'h00);
      fr.push_back(8'h00); fr.push_back(8'h00); end
    repeat (40) fr.push_back(8'h00); send_frame(fr);
    // good TCP, UDP, with VLAN and options
    build_frame(fr, 0, PROTO_TCP, 5, 5, 1, 16'd0); send_frame(fr);
    build_frame(fr, 1, PROTO_TCP, 15, 15, 3, 16'd0); send_frame(fr);
    build_frame(fr, 0, PROTO_UDP, 5, 0, 4, 16'hFFFF); send_frame(fr);
    build_frame(fr, 1, PROTO_UDP, 6, 0, 0, 16'd3); send_frame(fr);
    build_frame(fr, 0, PROTO_UDP, 5, 0, 0, 16'd8); send_frame(fr);
    // TCP without payload, small data offset, bad proto
    build_frame(fr, 0, PROTO_TCP, 5, 5, 0, 16'd0); send_frame(fr);
    build_frame(fr, 0, PROTO_TCP, 5, 0, 0, 16'd0); send_frame(fr);
    build_frame(fr, 0, 8'd1, 5, 5, 2, 16'd0); send_frame(fr);
    // small IHL, bad version, l4 short, ip short
    build_frame(fr, 0, PROTO_TCP, 2, 5, 4, 16'd0); send_frame(fr);
    build_frame(fr, 0, PROTO_TCP, 5, 5, 4, 16'd0); fr[14] = 8'h65; send_frame(fr);
    build_frame(fr, 0, PROTO_TCP, 5, 5, 0, 16'd0);
    repeat (5) void'(fr.pop_back()); send_frame(fr);
    build_frame(fr, 0, PROTO_UDP, 5, 0, 0, 16'd8);
    repeat (3) void'(fr.pop_back()); send_frame(fr);
    build_frame(fr, 0, PROTO_TCP, 5, 5, 0, 16'd0);
    while (fr.size() > 30) void'(fr.pop_back()); send_frame(fr);
    build_frame(fr, 0, PROTO_TCP, 12, 5, 0, 16'd0);
    while (fr.size() > 50) void'(fr.pop_back()); send_frame(fr);
  endtask

  // Receiver is told to hold off while the sender keeps offering frames
  task automatic test_backpressure();
    logic [7:0] fr[$];
    hold_rx = 1'b1;
    for (int i = 0; i < 12; i++) begin
      fr = {}; repeat ($urandom_range(1, 4)) fr.push_back(rand_byte());
      send_frame(fr);
    end
  endtask

  task automatic test_random(input int n_bytes);
    logic [7:0] fr[$];
    int sent, kind, cut;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(0, 9);
      build_frame(fr, $urandom_range(0, 3) == 0,
                  kind < 4 ? PROTO_TCP : kind < 8 ? PROTO_UDP : rand_byte(),
                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(5, 7),
                  $urandom_range(0, 15), $urandom_range(0, 6),
                  16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, fr.size());
        while (fr.size() > cut) void'(fr.pop_back());
      end
      if ($urandom_range(0, 9) == 0) fr[$urandom_range(0, fr.size() - 1)] = rand_byte();
      send_frame(fr);
      sent += fr.size();
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    push = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    err_count_q = '0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(80);
    push <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      fail_count++;
    end
    $display("Covered %0d frames, %0d results; status counts ok %0d, failures %0d",
             frames_sent, results_seen, status_hits[0], results_seen - status_hits[0]);
    $display("including short, VLAN, non-IP, bad IHL, short L4 and long stall cases");
    if (fail_count == 0) begin
      $display("eth_ipv4_l4_header_parser test passed");
    end else begin
      $display("eth_ipv4_l4_header_parser test failed");
    end
    $finish;
  end
endmodule
